>>> rtl/dfsts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfsts_pkg: shared definitions for the depth-first topological sort core
// Request codes, field widths, and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package dfsts_pkg;

	localparam int NODE_W        = 6;
	localparam int MAX_NODES_DEF = 32;

	localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(32);

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_EDGE  = 2'd1;
	localparam logic [1:0] REQ_RUN   = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// Commands from the controller, at most one walk step per cycle.
	typedef struct packed {
		logic clear_graph;
		logic load_req;
		logic write_edge;
		logic run_init;
		logic root_next;
		logic root_start;
		logic probe_next;
		logic push;
		logic pop;
		logic restore;
		logic emit_init;
		logic emit_step;
		logic emit_empty;
	} dfsts_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic root_done;
		logic root_elig;
		logic probe_end;
		logic probe_hit;
		logic depth_full;
		logic depth_one;
		logic count_zero;
		logic emit_last;
	} dfsts_sts_t;

endpackage
`default_nettype wire

>>> rtl/dfsts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfsts_ctrl: sequencer for the sort core
// Decodes requests and steps the walk, root scan and emit phases.
// ----------------------------------------------------------------------------
module dfsts_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [1:0]             req_type,
	input  dfsts_pkg::dfsts_sts_t       sts,
	output logic                        busy,
	output dfsts_pkg::dfsts_cmd_t       cmd
);
	import dfsts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_ROOT,
		S_PROBE,
		S_RESTORE,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_CLEAR: cmd.clear_graph = 1'b1;
						REQ_EDGE: begin
							cmd.load_req = 1'b1;
							state_d      = S_EDGE;
						end
						REQ_RUN: begin
							cmd.run_init = 1'b1;
							state_d      = S_ROOT;
						end
						default: ;
					endcase
				end
			end
			S_EDGE: begin
				cmd.write_edge = 1'b1;
				state_d        = S_IDLE;
			end
			S_ROOT: begin
				if (sts.root_done) begin
					if (sts.count_zero) begin
						cmd.emit_empty = 1'b1;
						state_d        = S_IDLE;
					end else begin
						cmd.emit_init = 1'b1;
						state_d       = S_EMIT;
					end
				end else if (sts.root_elig) begin
					cmd.root_start = 1'b1;
					state_d        = S_PROBE;
				end else begin
					cmd.root_next = 1'b1;
				end
			end
			S_PROBE: begin
				if (!sts.probe_end && sts.probe_hit && !sts.depth_full) begin
					cmd.push = 1'b1;
				end else if (!sts.probe_end && !sts.probe_hit) begin
					cmd.probe_next = 1'b1;
				end else begin
					cmd.pop = 1'b1;
					state_d = sts.depth_one ? S_ROOT : S_RESTORE;
				end
			end
			S_RESTORE: begin
				cmd.restore = 1'b1;
				state_d     = S_PROBE;
			end
			S_EMIT: begin
				cmd.emit_step = 1'b1;
				if (sts.emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/dfsts_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfsts_dp: datapath of the sort core
// Adjacency memory, walk stack, post-order memory, marks and counters.
// ----------------------------------------------------------------------------
module dfsts_dp #(
	parameter int MAX_NODES = dfsts_pkg::MAX_NODES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [dfsts_pkg::NODE_W-1:0] src_node,
	input  wire logic [dfsts_pkg::NODE_W-1:0] dst_node,
	input  wire logic                        cfg_write,
	input  wire logic [dfsts_pkg::NODE_W-1:0] cfg_data,
	input  dfsts_pkg::dfsts_cmd_t            cmd,
	output dfsts_pkg::dfsts_sts_t            sts,
	output logic                             result_valid,
	output logic [dfsts_pkg::NODE_W-1:0]     node_index,
	output logic                             last,
	output logic                             empty_res
);
	import dfsts_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int VW = NODE_W + 1;
	localparam logic [VW-1:0] MAXV = VW'(MAX_NODES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_NODES);

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [VW-1:0]     next;
	} frame_t;

	// Storage.
	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	frame_t               stk_mem [MAX_NODES];
	logic [NODE_W-1:0]    po_mem  [MAX_NODES];

	logic [MAX_NODES-1:0] adj_rd_q;
	logic                 adj_rdv_q;
	frame_t               stk_rd_q;
	logic [NODE_W-1:0]    po_rd_q;

	logic [NODE_W-1:0]    node_count_q;
	logic [NODE_W-1:0]    src_q;
	logic [NODE_W-1:0]    dst_q;
	logic                 edge_ok_q;
	logic [MAX_NODES-1:0] row_vld_q;
	logic [MAX_NODES-1:0] has_parent_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [VW-1:0]        root_q;
	logic [NODE_W-1:0]    cur_u_q;
	logic [VW-1:0]        cur_v_q;
	logic [CW-1:0]        depth_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        emit_q;
	logic                 out_valid_q;
	logic                 last_q;
	logic                 empty_q;

	// Derived values.
	logic [VW-1:0]        n_lim;
	logic [NODE_W-1:0]    src_m1;
	logic [NODE_W-1:0]    srcq_m1;
	logic [NODE_W-1:0]    dstq_m1;
	logic [VW-1:0]        root_m1;
	logic [VW-1:0]        v_m1;
	logic [NODE_W-1:0]    stk_u_m1;
	logic [CW-1:0]        depth_m1;
	logic [CW-1:0]        depth_m2;
	logic [CW-1:0]        count_m1;
	logic [IW-1:0]        root_idx;
	logic [IW-1:0]        v_idx;
	logic                 edge_ok;
	logic [MAX_NODES-1:0] row_eff;
	logic                 adj_re;
	logic [IW-1:0]        adj_ra;
	logic                 adj_we;
	logic [IW-1:0]        adj_wa;
	logic [MAX_NODES-1:0] adj_wd;
	logic                 po_we;

	always_comb begin
		n_lim    = ({1'b0, node_count_q} > MAXV) ? MAXV : {1'b0, node_count_q};
		src_m1   = src_node - 1'b1;
		srcq_m1  = src_q - 1'b1;
		dstq_m1  = dst_q - 1'b1;
		root_m1  = root_q - 1'b1;
		v_m1     = cur_v_q - 1'b1;
		stk_u_m1 = stk_rd_q.node - 1'b1;
		depth_m1 = depth_q - 1'b1;
		depth_m2 = depth_q - 2'd2;
		count_m1 = count_q - 1'b1;
		root_idx = root_m1[IW-1:0];
		v_idx    = v_m1[IW-1:0];
		edge_ok  = (src_node != '0) && ({1'b0, src_node} <= MAXV) &&
		           (dst_node != '0) && ({1'b0, dst_node} <= MAXV);
		row_eff  = adj_rdv_q ? adj_rd_q : '0;
	end

	// Adjacency port selection: one read and one write per cycle at most.
	always_comb begin
		adj_re = cmd.load_req | cmd.root_start | cmd.push | cmd.restore;
		if (cmd.load_req) begin
			adj_ra = src_m1[IW-1:0];
		end else if (cmd.root_start) begin
			adj_ra = root_idx;
		end else if (cmd.push) begin
			adj_ra = v_idx;
		end else begin
			adj_ra = stk_u_m1[IW-1:0];
		end
		adj_we = cmd.write_edge & edge_ok_q;
		adj_wa = srcq_m1[IW-1:0];
		adj_wd = row_eff | ({{(MAX_NODES-1){1'b0}}, 1'b1} << dstq_m1[IW-1:0]);
		po_we  = cmd.pop && (count_q != MAXC);
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_wa] <= adj_wd;
		end
		if (adj_re) begin
			adj_rd_q  <= adj_mem[adj_ra];
			adj_rdv_q <= row_vld_q[adj_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_mem[depth_m1[IW-1:0]] <= '{node: cur_u_q, next: cur_v_q + 1'b1};
		end
		if (cmd.pop) begin
			stk_rd_q <= stk_mem[depth_m2[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (po_we) begin
			po_mem[count_q[IW-1:0]] <= cur_u_q;
		end
		if (cmd.emit_step) begin
			po_rd_q <= po_mem[emit_q];
		end else if (cmd.emit_empty) begin
			po_rd_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			src_q     <= src_node;
			dst_q     <= dst_node;
			edge_ok_q <= edge_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			row_vld_q    <= '0;
			has_parent_q <= '0;
			visited_q    <= '0;
			root_q       <= '0;
			cur_u_q      <= '0;
			cur_v_q      <= '0;
			depth_q      <= '0;
			count_q      <= '0;
			emit_q       <= '0;
			out_valid_q  <= 1'b0;
			last_q       <= 1'b0;
			empty_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				node_count_q <= cfg_data;
			end
			if (cmd.clear_graph) begin
				row_vld_q    <= '0;
				has_parent_q <= '0;
			end
			if (adj_we) begin
				row_vld_q[adj_wa]                <= 1'b1;
				has_parent_q[dstq_m1[IW-1:0]]    <= 1'b1;
			end
			if (cmd.run_init) begin
				visited_q <= '0;
				count_q   <= '0;
				depth_q   <= '0;
				root_q    <= VW'(1);
			end
			if (cmd.root_next) begin
				root_q <= root_q + 1'b1;
			end
			if (cmd.root_start) begin
				visited_q[root_idx] <= 1'b1;
				cur_u_q             <= root_q[NODE_W-1:0];
				cur_v_q             <= VW'(1);
				depth_q             <= CW'(1);
				root_q              <= root_q + 1'b1;
			end
			if (cmd.probe_next) begin
				cur_v_q <= cur_v_q + 1'b1;
			end
			if (cmd.push) begin
				visited_q[v_idx] <= 1'b1;
				cur_u_q          <= cur_v_q[NODE_W-1:0];
				cur_v_q          <= VW'(1);
				depth_q          <= depth_q + 1'b1;
			end
			if (cmd.pop) begin
				depth_q <= depth_m1;
				if (po_we) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.restore) begin
				cur_u_q <= stk_rd_q.node;
				cur_v_q <= stk_rd_q.next;
			end
			if (cmd.emit_init) begin
				emit_q <= count_m1[IW-1:0];
			end
			if (cmd.emit_step) begin
				emit_q <= emit_q - 1'b1;
			end
			out_valid_q <= cmd.emit_step | cmd.emit_empty;
			last_q      <= cmd.emit_step && (emit_q == '0);
			empty_q     <= cmd.emit_empty;
		end
	end

	always_comb begin
		sts.root_done  = (root_q > n_lim);
		sts.root_elig  = !visited_q[root_idx] && !has_parent_q[root_idx];
		sts.probe_end  = (cur_v_q > n_lim);
		sts.probe_hit  = row_eff[v_idx] && !visited_q[v_idx];
		sts.depth_full = (depth_q == MAXC);
		sts.depth_one  = (depth_q == CW'(1));
		sts.count_zero = (count_q == '0);
		sts.emit_last  = (emit_q == '0);
	end

	assign result_valid = out_valid_q;
	assign node_index   = po_rd_q;
	assign last         = last_q;
	assign empty_res    = empty_q;

endmodule
`default_nettype wire

>>> rtl/dfs_topological_sort_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_topological_sort_core: depth-first topological sort engine
// Loads directed edges into an adjacency memory and, on request, emits the
// nodes in topological order found by a depth-first walk.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. A clear request
// leaves busy low; an add-edge request reads the source row and writes it
// back, holding busy for one cycle. A run request scans the roots in
// increasing index and walks from every parentless node, probing one child
// of the current node per cycle through the single adjacency read port, so
// the walk spends its time probing the candidate children of each visited
// node, checking each root candidate, ending the root scan and returning to
// each parent. The ordered words then follow on consecutive cycles, one per
// node, with last high on the final one; when no parentless node exists a
// single word with empty_res high is given instead. Each result word is on
// the result ports for one cycle only, marked by result_valid: the receiver
// cannot stall the block and must take every word as it comes. Nodes reached
// only through cycles are not emitted. Adjacency rows carry valid bits that a
// clear drops, so no clearing pass is needed after reset. node_count may be
// written whenever the core is idle.
// ----------------------------------------------------------------------------
module dfs_topological_sort_core #(
	parameter int MAX_NODES = dfsts_pkg::MAX_NODES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   req_type,
	input  wire logic [dfsts_pkg::NODE_W-1:0] src_node,
	input  wire logic [dfsts_pkg::NODE_W-1:0] dst_node,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [dfsts_pkg::NODE_W-1:0] cfg_data,
	output logic                              result_valid,
	output logic [dfsts_pkg::NODE_W-1:0]      node_index,
	output logic                              last,
	output logic                              empty_res
);
	import dfsts_pkg::*;

	dfsts_cmd_t cmd;
	dfsts_sts_t sts;

	// The register write is always taken in the cycle it is offered.
	assign cfg_ready = 1'b1;

	dfsts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	dfsts_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_node     (src_node),
		.dst_node     (dst_node),
		.cfg_write    (cfg_valid & cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.node_index   (node_index),
		.last         (last),
		.empty_res    (empty_res)
	);

	// The walk takes at most one step per cycle.
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push, cmd.pop, cmd.probe_next, cmd.restore, cmd.root_start,
		          cmd.emit_step}))
		else $error("more than one walk step in a cycle");

	// An accepted edge request holds the core busy while its row is written back.
	a_edge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_EDGE) |=> busy)
		else $error("edge request did not hold busy");

	// The emitted order runs without gaps up to its last word.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last && !empty_res) |=> (result_valid && !empty_res))
		else $error("gap in emitted order");

	// The empty result carries node zero and no last mark.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && empty_res) |-> (node_index == '0 && !last))
		else $error("malformed empty result");

	// Nothing follows the last word directly.
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !result_valid)
		else $error("result word after last");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the depth-first topological sort core
// Drives clear, add-edge and run requests through the start/busy command
// port and writes node_count through the configuration channel. A scoreboard
// class keeps its own graph and predicts the order words of every run. Each
// result word is checked field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_top;

	import dfsts_pkg::*;

	// The core is built with its default size, so the predictor uses the same.
	localparam int NODES = MAX_NODES_DEF;

	// The watchdog allows far longer than the longest walk of a run over 32
	// nodes before its first word appears, with nothing accepted meanwhile.
	localparam int QUIET_LIMIT = 20000;

	// Cycles allowed after the last expected word before a register write or
	// the end of the run. An add-edge request keeps busy high for one cycle.
	localparam int SETTLE_CYCLES = 8;

	typedef logic [NODE_W-1:0] node_t;

	// One result word as the core presents it.
	typedef struct packed {
		node_t node;
		logic  last;
		logic  empty;
	} order_word_t;

	// ------------------------------------------------------------------------
	// Scoreboard. It holds its own copy of the graph and of node_count, works
	// out the order words of each run request as the request is accepted, and
	// checks every result word against the oldest one still waiting.
	// ------------------------------------------------------------------------
	class topo_order_board;
		logic [NODES-1:0] adjacency [NODES];
		logic [NODES-1:0] parented;
		node_t            node_count;
		order_word_t      pending_words [$];
		int               mismatches;
		int               words_checked;

		function new();
			clear_graph();
			node_count    = NODE_COUNT_RST;
			mismatches    = 0;
			words_checked = 0;
		endfunction

		function void clear_graph();
			foreach (adjacency[i])
				adjacency[i] = '0;
			parented = '0;
		endfunction

		function void set_node_count(node_t value);
			node_count = value;
		endfunction

		// Appends one expected word behind those already waiting.
		function void queue_word(order_word_t w);
			pending_words.insert(pending_words.size(), w);
		endfunction

		function void report(string what, order_word_t want, order_word_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: expected node %0d last %0b empty %0b, got node %0d last %0b empty %0b",
					what, want.node, want.last, want.empty, got.node, got.last, got.empty);
		endfunction

		// Walks depth first from every parentless node in use, in increasing
		// index, and queues the reverse of the whole post order.
		function void predict_order();
			int               limit;
			int               count;
			int               depth;
			int               top;
			int               u;
			int               v;
			int               found;
			int               stack_node [NODES];
			int               stack_next [NODES];
			int               finished [NODES];
			logic [NODES-1:0] seen;
			order_word_t      w;

			limit = (node_count > NODES) ? NODES : int'(node_count);
			count = 0;
			seen  = '0;
			for (int r = 1; r <= limit; r++) begin
				if (!seen[r-1] && !parented[r-1]) begin
					seen[r-1]     = 1'b1;
					stack_node[0] = r;
					stack_next[0] = 1;
					depth         = 1;
					while (depth > 0) begin
						top   = depth - 1;
						u     = stack_node[top];
						found = 0;
						for (v = stack_next[top]; v <= limit; v++) begin
							if (adjacency[u-1][v-1] && !seen[v-1]) begin
								found = v;
								break;
							end
						end
						if (found != 0 && depth < NODES) begin
							stack_next[top]   = found + 1;
							seen[found-1]     = 1'b1;
							stack_node[depth] = found;
							stack_next[depth] = 1;
							depth++;
						end else begin
							if (count < NODES) begin
								finished[count] = u;
								count++;
							end
							depth--;
						end
					end
				end
			end
			if (count == 0) begin
				w.node  = '0;
				w.last  = 1'b0;
				w.empty = 1'b1;
				queue_word(w);
			end else begin
				for (int i = 0; i < count; i++) begin
					w.node  = node_t'(finished[count-1-i]);
					w.last  = (i == count - 1);
					w.empty = 1'b0;
					queue_word(w);
				end
			end
		endfunction

		function void note_request(logic [1:0] req, node_t src, node_t dst);
			case (req)
				REQ_CLEAR: begin
					clear_graph();
				end
				REQ_EDGE: begin
					// Edges naming node zero or a node past the array are dropped.
					if (src >= 1 && src <= NODES && dst >= 1 && dst <= NODES) begin
						adjacency[src-1][dst-1] = 1'b1;
						parented[dst-1]         = 1'b1;
					end
				end
				REQ_RUN: begin
					predict_order();
				end
				default: begin
				end
			endcase
		endfunction

		function void check_word(node_t node, logic last, logic empty);
			order_word_t got;
			order_word_t want;

			got.node  = node;
			got.last  = last;
			got.empty = empty;
			words_checked++;
			if (pending_words.size() == 0) begin
				report("unexpected word", '0, got);
			end else begin
				want = pending_words.pop_front();
				if (want !== got)
					report("mismatch", want, got);
			end
		endfunction

		// Anything still queued at the end never arrived.
		function void close_out();
			while (pending_words.size() != 0)
				report("missing word", pending_words.pop_front(), 'x);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the signals of the core. Every input starts known.
	// ------------------------------------------------------------------------
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  req_type   = REQ_CLEAR;
	node_t       src_node   = '0;
	node_t       dst_node   = '0;
	logic        cfg_valid  = 1'b0;
	node_t       cfg_data   = '0;
	logic        busy;
	logic        cfg_ready;
	logic        result_valid;
	node_t       node_index;
	logic        last;
	logic        empty_res;

	topo_order_board board;

	int idle_pct;
	int items_sent;
	int runs_sent;
	int edges_sent;
	int clears_sent;
	int cfg_writes;
	int quiet_cycles;

	always #2 clk = ~clk;

	dfs_topological_sort_core #(
		.MAX_NODES(NODES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.src_node    (src_node),
		.dst_node    (dst_node),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.node_index  (node_index),
		.last        (last),
		.empty_res   (empty_res)
	);

	// ------------------------------------------------------------------------
	// Monitor. Everything is sampled at the rising edge, where the values seen
	// are the ones held through the cycle that the edge ends. Request words,
	// register writes and result words all go through this one block, so the
	// scoreboard sees them in a fixed order.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.set_node_count(cfg_data);
			if (start && !busy)
				board.note_request(req_type, src_node, dst_node);
			if (result_valid)
				board.check_word(node_index, last, empty_res);
		end
	end

	// Watchdog: counts cycles in which no word of any kind moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks.
	// ------------------------------------------------------------------------

	// Offers one request word. In each cycle start is raised or left low at
	// random, so gaps land both while the core is idle and while it is busy
	// with a walk. The task returns at the edge that took the word and leaves
	// start as it is, so the next word can follow without a gap.
	task automatic send_request(logic [1:0] req, node_t src, node_t dst);
		logic offer;

		do begin
			offer = ($urandom_range(99) >= idle_pct);
			start    <= offer;
			req_type <= req;
			src_node <= src;
			dst_node <= dst;
			@(posedge clk);
		end while (!(offer && !busy));
		case (req)
			REQ_CLEAR: clears_sent++;
			REQ_EDGE:  edges_sent++;
			REQ_RUN:   runs_sent++;
			default:   ;
		endcase
		if (req != REQ_NONE)
			items_sent++;
	endtask

	// Lowers start and waits until every expected word has arrived and the
	// core has dropped busy, then lets a few more cycles pass. Register writes
	// happen only after this.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_words.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_node_count(node_t value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	// Mostly small node counts so that walks stay short, with the extremes
	// and out-of-range values mixed in now and then.
	function automatic node_t pick_node_count();
		case ($urandom_range(19))
			0:       return '0;
			1:       return node_t'(1);
			2:       return node_t'(NODES);
			3:       return '1;
			4:       return node_t'($urandom_range(63, NODES + 1));
			default: return node_t'($urandom_range(12, 2));
		endcase
	endfunction

	// Edges mostly run from a lower to a higher node in use, which keeps the
	// graph acyclic and the walks deep. Some point backwards to close cycles,
	// and a few carry any six-bit value, out of range ones included.
	task automatic add_random_edge(int span);
		node_t a;
		node_t b;
		node_t t;

		if ($urandom_range(9) == 0) begin
			a = node_t'($urandom_range(63));
			b = node_t'($urandom_range(63));
		end else begin
			a = node_t'($urandom_range(span, 1));
			b = node_t'($urandom_range(span, 1));
			if ($urandom_range(6) != 0 && a > b) begin
				t = a;
				a = b;
				b = t;
			end
		end
		send_request(REQ_EDGE, a, b);
	endtask

	// A well-formed sequence: usually a clear, then a batch of edges among
	// the nodes in use, then a run.
	task automatic build_and_sort();
		int span;
		int edge_total;

		span = (board.node_count == 0) ? 4 :
			(board.node_count > NODES) ? NODES : int'(board.node_count);
		if (span < 2)
			span = 2;
		edge_total = $urandom_range(2 * span);
		if ($urandom_range(3) != 0)
			send_request(REQ_CLEAR, node_t'($urandom_range(63)), node_t'($urandom_range(63)));
		repeat (edge_total)
			add_random_edge(span);
		send_request(REQ_RUN, node_t'($urandom_range(63)), node_t'($urandom_range(63)));
	endtask

	// One random phase at a given idle rate. Every few sequences the core is
	// drained and node_count is written again.
	task automatic random_phase(int pct, int quota);
		int first;

		first    = items_sent;
		idle_pct = pct;
		while (items_sent - first < quota) begin
			wait_idle();
			write_node_count(pick_node_count());
			repeat (3) begin
				if ($urandom_range(4) != 0) begin
					build_and_sort();
				end else begin
					// Noise: any request code, the unused one included, with
					// random node fields.
					repeat ($urandom_range(3, 1))
						send_request(2'($urandom_range(3)), node_t'($urandom_range(63)),
							node_t'($urandom_range(63)));
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		board       = new();
		idle_pct    = 0;
		items_sent  = 0;
		runs_sent   = 0;
		edges_sent  = 0;
		clears_sent = 0;
		cfg_writes  = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset node count of 32. A run on the empty
		// graph makes every node a root and emits all of them.
		send_request(REQ_RUN, '0, '0);
		// The unused request code must be ignored.
		send_request(REQ_NONE, node_t'(5), node_t'(9));
		// A small acyclic graph, a self loop, a two-node cycle that no root
		// reaches, and edges naming node zero or nodes past the array.
		send_request(REQ_EDGE, node_t'(1), node_t'(2));
		send_request(REQ_EDGE, node_t'(2), node_t'(3));
		send_request(REQ_EDGE, node_t'(1), node_t'(3));
		send_request(REQ_EDGE, node_t'(5), node_t'(4));
		send_request(REQ_EDGE, '0, node_t'(3));
		send_request(REQ_EDGE, node_t'(3), node_t'(33));
		send_request(REQ_EDGE, '1, node_t'(1));
		send_request(REQ_EDGE, node_t'(32), node_t'(31));
		send_request(REQ_EDGE, node_t'(8), node_t'(8));
		send_request(REQ_EDGE, node_t'(6), node_t'(7));
		send_request(REQ_EDGE, node_t'(7), node_t'(6));
		send_request(REQ_RUN, '0, '0);
		send_request(REQ_CLEAR, '1, '1);
		send_request(REQ_RUN, '0, '0);

		// Two nodes in use, each with a parent: the run gives the empty word.
		// The edge to node 20 lies beyond the nodes in use.
		wait_idle();
		write_node_count(node_t'(2));
		send_request(REQ_EDGE, node_t'(1), node_t'(2));
		send_request(REQ_EDGE, node_t'(2), node_t'(1));
		send_request(REQ_EDGE, node_t'(2), node_t'(20));
		send_request(REQ_RUN, '0, '0);

		// No nodes in use at all.
		wait_idle();
		write_node_count('0);
		send_request(REQ_RUN, '0, '0);

		// A single node.
		wait_idle();
		write_node_count(node_t'(1));
		send_request(REQ_CLEAR, '0, '0);
		send_request(REQ_RUN, '0, '0);

		// A node count past the array acts as the full array.
		wait_idle();
		write_node_count('1);
		send_request(REQ_EDGE, node_t'(1), node_t'(32));
		send_request(REQ_RUN, '0, '0);

		// Random part: a light sender gap rate, then a heavy one, then none.
		random_phase(6, 70);
		random_phase(74, 70);
		random_phase(0, 70);

		wait_idle();
		board.close_out();

		$display("Covered %0d request words (%0d edges, %0d clears, %0d runs) and %0d node_count writes.",
			items_sent, edges_sent, clears_sent, runs_sent, cfg_writes);
		$display("Checked %0d order words, %0d of them wrong, missing or unexpected.",
			board.words_checked, board.mismatches);
		if (board.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> dfs_topological_sort_core.f
rtl/dfsts_pkg.sv
rtl/dfsts_ctrl.sv
rtl/dfsts_dp.sv
rtl/dfs_topological_sort_core.sv
dv/tb_top.sv
